/* hdl/ptba_pkg.sv */
package ptba_pkg;

  // map word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  // default geometry
  localparam int DEF_POOL_ENTRIES = 1024;
  localparam int DEF_FRAME_BYTES  = 4096;

  // config field widths
  localparam int CNT_CFG_W = 11;
  localparam int ADDR_W    = 32;

  // request codes
  localparam logic [1:0] REQ_ALLOC      = 2'd0;
  localparam logic [1:0] REQ_FREE_INDEX = 2'd1;
  localparam logic [1:0] REQ_FREE_ADDR  = 2'd2;
  localparam logic [1:0] REQ_INIT       = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NONE_FREE     = 3'd1;
  localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd2;
  localparam logic [2:0] ST_MISALIGNED    = 3'd3;
  localparam logic [2:0] ST_BEYOND_POOL   = 3'd4;
  localparam logic [2:0] ST_INVALID_INDEX = 3'd5;
  localparam logic [2:0] ST_ALREADY_FREE  = 3'd6;

  // config register indexes
  localparam logic [1:0] REG_TABLE_COUNT    = 2'd0;
  localparam logic [1:0] REG_RESERVED_COUNT = 2'd1;
  localparam logic [1:0] REG_VIRT_BASE      = 2'd2;
  localparam logic [1:0] REG_PHYS_BASE      = 2'd3;

  // config reset values
  localparam logic [CNT_CFG_W-1:0] RST_TABLE_COUNT    = 11'd1024;
  localparam logic [CNT_CFG_W-1:0] RST_RESERVED_COUNT = 11'd0;
  localparam logic [ADDR_W-1:0]    RST_VIRT_BASE      = 32'hFFC0_0000;
  localparam logic [ADDR_W-1:0]    RST_PHYS_BASE      = 32'h0040_0000;
  localparam logic [ADDR_W-1:0]    ADDR_ALL_ONES      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                 found;
    logic [WORD_SH-1:0]   pos;
  } zero_pos_t;

  // bits of the word starting at entry lo whose entry index is below n
  function automatic logic [WORD_W-1:0] row_mask(input logic [31:0] n, input logic [31:0] lo);
    logic [31:0] span;
    span = n - lo;
    if (n <= lo) begin
      return '0;
    end else if (span >= 32'(WORD_W)) begin
      return '1;
    end else begin
      return (32'h1 << span[WORD_SH-1:0]) - 32'h1;
    end
  endfunction

  // lowest clear bit of a word
  function automatic zero_pos_t first_zero(input logic [WORD_W-1:0] w);
    zero_pos_t r;
    r = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!w[j]) begin
        r.found = 1'b1;
        r.pos   = WORD_SH'(j);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/page_table_bitmap_allocator.sv */
// channel    direction  ports                                         handshake
// request    in         req_type_i, table_index_i, virtual_address_i  start & !busy
// result     out        status_o, entry_index_o, frame_address_o,     done strobe
//                       used_count_o
// config     in         cfg_index_i, cfg_data_i                       cfg_we_i
//
// allocate scans the map one 32-entry row per cycle, bound by the single read port
// of the map memory.
// initialize writes one row per cycle.
// free passes through decode, row read and update; a request rejected at decode ends there.
// reset marks every entry free at once through per-row valid bits; no clear pass.
// the result is shown for one cycle with done_o; the receiver cannot stall it.
module page_table_bitmap_allocator #(
  parameter int POOL_ENTRIES = ptba_pkg::DEF_POOL_ENTRIES,
  parameter int FRAME_BYTES  = ptba_pkg::DEF_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  table_index_i,
  input  logic [31:0] virtual_address_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [9:0]  entry_index_o,
  output logic [31:0] frame_address_o,
  output logic [10:0] used_count_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ptba_pkg::*;

  localparam int ROWS  = (POOL_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int FB_SH = $clog2(FRAME_BYTES);
  localparam int IDX_W = ROW_W + WORD_SH;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_INIT     = 3'd3;
  localparam logic [2:0] S_FREE_CHK = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [1:0]           req_q;
  logic [9:0]           tidx_q;
  logic [ADDR_W-1:0]    vaddr_q;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     chk_row_q, chk_row_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [2:0]           status_q, status_d;
  logic [9:0]           entry_q, entry_d;
  logic [ADDR_W-1:0]    frame_q, frame_d;

  logic [CNT_CFG_W-1:0] table_count_q;
  logic [CNT_CFG_W-1:0] reserved_count_q;
  logic [ADDR_W-1:0]    virt_base_q;
  logic [ADDR_W-1:0]    phys_base_q;

  logic [CNT_W-1:0]     tc, rc;
  logic [31:0]          off32;
  logic [IDX_W-1:0]     free_idx;
  logic [ROW_W-1:0]     rd_addr;
  logic [WORD_W-1:0]    rd_data;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [WORD_W-1:0]    scan_word;
  zero_pos_t            zp;
  logic [IDX_W-1:0]     found_idx;
  logic [31:0]          ent32;
  logic [31:0]          cnt32;

  assign busy = (state_q != S_IDLE);

  // effective pool and reserved sizes
  assign tc = (32'(table_count_q) > 32'(POOL_ENTRIES)) ? CNT_W'(POOL_ENTRIES)
                                                        : CNT_W'(table_count_q);
  assign rc = (32'(reserved_count_q) > 32'(POOL_ENTRIES)) ? CNT_W'(POOL_ENTRIES)
                                                           : CNT_W'(reserved_count_q);

  // entry addressed by a free request
  assign off32    = (vaddr_q - virt_base_q) >> FB_SH;
  assign free_idx = (req_q == REQ_FREE_INDEX) ? IDX_W'(tidx_q) : IDX_W'(off32);

  // scan unit: lowest free entry of the row under check
  assign scan_word = rd_data | ~row_mask(32'(tc), 32'(chk_row_q) << WORD_SH);
  assign zp        = first_zero(scan_word);
  assign found_idx = {chk_row_q, zp.pos};

  // map read address
  always_comb begin
    if (state_q == S_DECODE) begin
      rd_addr = (req_q == REQ_ALLOC) ? '0 : free_idx[IDX_W-1:WORD_SH];
    end else begin
      rd_addr = row_q;
    end
  end

  ptba_map #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    chk_row_d = chk_row_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    entry_d   = entry_q;
    frame_d   = frame_q;
    wr_en     = 1'b0;
    wr_addr   = row_q;
    wr_data   = '0;
    ent32     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_q)
          REQ_ALLOC: begin
            chk_row_d = '0;
            row_d     = (LAST_ROW == '0) ? '0 : ROW_W'(1);
            state_d   = S_SCAN;
          end
          REQ_FREE_INDEX: begin
            if (32'(tidx_q) >= 32'(tc)) begin
              done_d   = 1'b1;
              status_d = ST_INVALID_INDEX;
              entry_d  = tidx_q;
              frame_d  = '0;
              state_d  = S_IDLE;
            end else begin
              idx_d   = free_idx;
              state_d = S_FREE_CHK;
            end
          end
          REQ_FREE_ADDR: begin
            done_d   = 1'b1;
            entry_d  = '0;
            frame_d  = '0;
            state_d  = S_IDLE;
            if (vaddr_q < virt_base_q || vaddr_q == ADDR_ALL_ONES) begin
              status_d = ST_OUT_OF_RANGE;
            end else if ((vaddr_q & 32'(FRAME_BYTES - 1)) != '0) begin
              status_d = ST_MISALIGNED;
            end else if (off32 >= 32'(tc)) begin
              status_d = ST_BEYOND_POOL;
            end else begin
              done_d  = 1'b0;
              idx_d   = free_idx;
              state_d = S_FREE_CHK;
            end
          end
          default: begin
            row_d   = '0;
            cnt_d   = rc;
            state_d = S_INIT;
          end
        endcase
      end
      S_SCAN: begin
        chk_row_d = row_q;
        if (row_q != LAST_ROW) begin
          row_d = row_q + ROW_W'(1);
        end
        if (zp.found) begin
          wr_en    = 1'b1;
          wr_addr  = chk_row_q;
          wr_data  = rd_data | (WORD_W'(1) << zp.pos);
          cnt_d    = cnt_q + CNT_W'(1);
          ent32    = 32'(found_idx);
          done_d   = 1'b1;
          status_d = ST_OK;
          entry_d  = ent32[9:0];
          frame_d  = phys_base_q + (32'(found_idx) << FB_SH);
          state_d  = S_IDLE;
        end else if (chk_row_q == LAST_ROW) begin
          done_d   = 1'b1;
          status_d = ST_NONE_FREE;
          entry_d  = '0;
          frame_d  = '0;
          state_d  = S_IDLE;
        end
      end
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = row_q;
        wr_data = row_mask(32'(rc), 32'(row_q) << WORD_SH);
        if (row_q == LAST_ROW) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          entry_d  = '0;
          frame_d  = '0;
          state_d  = S_IDLE;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      S_FREE_CHK: begin
        ent32   = 32'(idx_q);
        entry_d = ent32[9:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!rd_data[idx_q[WORD_SH-1:0]]) begin
          status_d = ST_ALREADY_FREE;
          frame_d  = '0;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = idx_q[IDX_W-1:WORD_SH];
          wr_data  = rd_data & ~(WORD_W'(1) << idx_q[WORD_SH-1:0]);
          cnt_d    = cnt_q - CNT_W'(1);
          status_d = ST_OK;
          frame_d  = phys_base_q + (32'(idx_q) << FB_SH);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // item and sequencer payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q   <= req_type_i;
      tidx_q  <= table_index_i;
      vaddr_q <= virtual_address_i;
    end
    row_q     <= row_d;
    chk_row_q <= chk_row_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    entry_q   <= entry_d;
    frame_q   <= frame_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count_q    <= RST_TABLE_COUNT;
      reserved_count_q <= RST_RESERVED_COUNT;
      virt_base_q      <= RST_VIRT_BASE;
      phys_base_q      <= RST_PHYS_BASE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TABLE_COUNT:    table_count_q    <= cfg_data_i[CNT_CFG_W-1:0];
        REG_RESERVED_COUNT: reserved_count_q <= cfg_data_i[CNT_CFG_W-1:0];
        REG_VIRT_BASE:      virt_base_q      <= cfg_data_i;
        REG_PHYS_BASE:      phys_base_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // result ports
  assign cnt32           = 32'(cnt_q);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign entry_index_o   = entry_q;
  assign frame_address_o = frame_q;
  assign used_count_o    = cnt32[10:0];

endmodule

/* hdl/ptba_map.sv */
module ptba_map #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ROW_W-1:0]            rd_addr_i,
  output logic [ptba_pkg::WORD_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [ROW_W-1:0]            wr_addr_i,
  input  logic [ptba_pkg::WORD_W-1:0] wr_data_i
);
  import ptba_pkg::*;

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]   row_valid_q;

  // row storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // rows never written read as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (wr_en_i) begin
      row_valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= row_valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

endmodule
